// ===== rtl/tis_pkg.sv =====
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types and constants for the telnet command stripper.
// ----------------------------------------------------------------------------
package tis_pkg;

  localparam int unsigned MAX_BUFFER_DEF = 512;
  localparam int unsigned COUNT_W        = 10;
  localparam int unsigned SKIP_W         = 4;
  localparam int unsigned NAWS_LENGTH    = 9;

  localparam logic [7:0] BYTE_IAC = 8'd255;
  localparam logic [7:0] BYTE_NOP = 8'd241;
  localparam logic [7:0] BYTE_SB  = 8'd250;
  localparam logic [7:0] OPT_NAWS = 8'd31;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_NUL = 8'd0;

  localparam logic [SKIP_W-1:0] NAWS_SKIP = SKIP_W'(NAWS_LENGTH - 3);

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_CR,
    MODE_IAC,
    MODE_CMD,
    MODE_SKIP
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic               keep;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

endpackage

// ===== rtl/telnet_iac_stripper_unit.sv =====
// ----------------------------------------------------------------------------
// telnet_iac_stripper_unit
// Strip telnet command sequences from a byte stream, one byte per beat.
// Registers: the input register holds each beat for the parser, and the result register holds its result.
// Throughput: one beat per cycle while out_stall is low; the parser state updates on each accepted beat.
// Reset: synchronous, clears both valid flags and the parser to normal mode.
// ----------------------------------------------------------------------------
module telnet_iac_stripper_unit
  import tis_pkg::*;
#(
  parameter int unsigned MAX_BUFFER = MAX_BUFFER_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_in,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               keep,
  output logic [7:0]         data_out,
  output logic [COUNT_W-1:0] kept_count,
  output logic               buffer_end
);

  logic    s1_valid;
  item_t   s1_item;
  logic    s2_ready;
  logic    advance;
  result_t res;

  assign advance = s1_valid && s2_ready;

  tis_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .data_in  (data_in),
    .last_in  (last_in),
    .take     (s2_ready),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  tis_parser #(
    .MAX_BUFFER (MAX_BUFFER)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .res     (res)
  );

  tis_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (s1_valid),
    .res        (res),
    .ready      (s2_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .keep       (keep),
    .data_out   (data_out),
    .kept_count (kept_count),
    .buffer_end (buffer_end)
  );

endmodule

// ===== rtl/tis_in_stage.sv =====
// ----------------------------------------------------------------------------
// tis_in_stage
// Input register: capture one beat and hold it until the parser advances.
// ----------------------------------------------------------------------------
module tis_in_stage
  import tis_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_in,
  input  logic       last_in,
  input  logic       take,
  output logic       valid,
  output item_t      item
);

  logic ready;

  assign ready    = !valid || take;
  assign in_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      item <= '{data: data_in, last: last_in};
    end
  end

endmodule

// ===== rtl/tis_parser.sv =====
// ----------------------------------------------------------------------------
// tis_parser
// Command parser: decide keep or drop for one byte and update the state.
// ----------------------------------------------------------------------------
module tis_parser
  import tis_pkg::*;
#(
  parameter int unsigned MAX_BUFFER = MAX_BUFFER_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  output result_t res
);

  localparam int unsigned CW = $clog2(MAX_BUFFER + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BUFFER);

  mode_t             mode;
  mode_t             mode_next;
  logic [7:0]        command_byte;
  logic [7:0]        command_byte_next;
  logic [SKIP_W-1:0] skip_left;
  logic [SKIP_W-1:0] skip_left_next;
  logic [CW-1:0]     kept_total;
  logic [CW-1:0]     kept_total_next;
  logic [CW-1:0]     kept_inc;
  logic              keep;
  logic              lf_or_nul;

  assign lf_or_nul = (item.data == BYTE_LF) || (item.data == BYTE_NUL);

  always_comb begin
    mode_next         = mode;
    command_byte_next = command_byte;
    skip_left_next    = skip_left;
    case (mode)
      MODE_NORMAL: begin
        mode_next = (item.data == BYTE_IAC) ? MODE_IAC :
                    (item.data == BYTE_CR)  ? MODE_CR  : MODE_NORMAL;
      end
      MODE_CR: begin
        mode_next = lf_or_nul                ? MODE_NORMAL :
                    (item.data == BYTE_IAC)  ? MODE_IAC    :
                    (item.data == BYTE_CR)   ? MODE_CR     : MODE_NORMAL;
      end
      MODE_IAC: begin
        if (item.data == BYTE_NOP || item.data == BYTE_IAC) begin
          mode_next = MODE_NORMAL;
        end else begin
          command_byte_next = item.data;
          mode_next         = MODE_CMD;
        end
      end
      MODE_CMD: begin
        if (command_byte == BYTE_SB && item.data == OPT_NAWS) begin
          skip_left_next = NAWS_SKIP;
          mode_next      = MODE_SKIP;
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_SKIP: begin
        if (skip_left <= SKIP_W'(1)) begin
          skip_left_next = '0;
          mode_next      = MODE_NORMAL;
        end else begin
          skip_left_next = skip_left - SKIP_W'(1);
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase
    if (item.last) begin
      mode_next      = MODE_NORMAL;
      skip_left_next = '0;
    end
  end

  always_comb begin
    case (mode)
      MODE_NORMAL: keep = (item.data != BYTE_IAC);
      MODE_CR:     keep = !lf_or_nul && (item.data != BYTE_IAC);
      MODE_IAC:    keep = (item.data == BYTE_IAC);
      default:     keep = 1'b0;
    endcase
  end

  assign kept_inc        = (keep && kept_total < MAX_CNT) ? kept_total + CW'(1) : kept_total;
  assign kept_total_next = item.last ? '0 : kept_inc;

  assign res.keep  = keep;
  assign res.data  = keep ? item.data : 8'd0;
  assign res.count = COUNT_W'(kept_inc);
  assign res.last  = item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      command_byte <= '0;
      skip_left    <= '0;
      kept_total   <= '0;
    end else if (advance) begin
      mode         <= mode_next;
      command_byte <= command_byte_next;
      skip_left    <= skip_left_next;
      kept_total   <= kept_total_next;
    end
  end

  a_skip_only_in_skip: assert property (@(posedge clk) disable iff (rst)
    (skip_left != '0) |-> (mode == MODE_SKIP))
    else $error("skip count live outside skip mode");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    kept_total <= MAX_CNT)
    else $error("kept count above buffer size");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && item.last) |=>
      (mode == MODE_NORMAL && skip_left == '0 && kept_total == '0))
    else $error("buffer end did not clear parser state");

endmodule

// ===== rtl/tis_out_stage.sv =====
// ----------------------------------------------------------------------------
// tis_out_stage
// Result register: hold one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module tis_out_stage
  import tis_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  result_t            res,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               keep,
  output logic [7:0]         data_out,
  output logic [COUNT_W-1:0] kept_count,
  output logic               buffer_end
);

  result_t held;

  assign ready      = !out_valid || !out_stall;
  assign keep       = held.keep;
  assign data_out   = held.data;
  assign kept_count = held.count;
  assign buffer_end = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && res_valid) begin
      held <= res;
    end
  end

endmodule
